>>> hdl/adfp_pkg.sv
package adfp_pkg;

   localparam int FRAC_BITS       = 16;
   localparam int MAX_FRAC_DIGITS = 6;

   localparam int CHAR_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int INT_W      = 15;
   localparam int FRAC_ACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
   localparam int COUNT_W    = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int STEP_W     = $clog2(FRAC_BITS);
   localparam int MAG_W      = INT_W + FRAC_BITS;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [INT_W-1:0] INT_MAX = '1;

   // controller to datapath
   typedef struct packed {
      logic take_char;  // transfer on the request side this cycle
      logic div_step;   // advance the divider by one quotient bit
      logic load_out;   // load the result register and clear the number
   } adfp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_term;    // presented character ends the number
   } adfp_status_type;

   // 10^n for the kept fraction digit count; small constant table
   function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [COUNT_W-1:0] n);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < MAX_FRAC_DIGITS; i++) begin
         if (i < int'(n)) begin
            p = p * 64'd10;
         end
      end
      return p[FRAC_ACC_W-1:0];
   endfunction

endpackage

>>> hdl/adfp_ctrl.sv
module adfp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  adfp_pkg::adfp_status_type status,
   output adfp_pkg::adfp_cmd_type    cmd
);
   import adfp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_FINISH = 3'b100
   } adfp_state_type;

   adfp_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   logic              accept, out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      cmd.take_char = 1'b0;
      cmd.div_step  = 1'b0;
      cmd.load_out  = 1'b0;
      valid_in      = valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_char = accept;
            if (accept && status.is_term) begin
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_BITS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

endmodule

>>> hdl/adfp_datapath.sv
module adfp_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [adfp_pkg::CHAR_W-1:0]      req_char_in,
   input  adfp_pkg::adfp_cmd_type           cmd,
   output adfp_pkg::adfp_status_type        status,
   output logic signed [adfp_pkg::VALUE_W-1:0] rsp_value,
   output logic                             rsp_overflow
);
   import adfp_pkg::*;

   typedef enum logic [2:0] {
      PH_START = 3'b001,
      PH_INT   = 3'b010,
      PH_FRAC  = 3'b100
   } adfp_phase_type;

   adfp_phase_type        phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [INT_W-1:0]      int_ff, int_in;
   logic                  sat_ff, sat_in;
   logic [FRAC_ACC_W-1:0] frac_ff, frac_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic [FRAC_ACC_W-1:0] rem_ff, rem_in;
   logic [FRAC_ACC_W-1:0] dvsr_ff, dvsr_in;
   logic [FRAC_BITS-1:0]  quo_ff, quo_in;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic                  ovf_ff, ovf_in;

   logic                  is_digit, is_point, is_sign, is_term;
   logic [3:0]            digit;
   logic [INT_W+3:0]      int_sum;
   logic [FRAC_ACC_W:0]   rem_shift;
   logic                  rem_ge;
   logic [63:0]           mag_wide;
   logic                  clamp;
   logic [VALUE_W-1:0]    mag;

   assign is_digit = req_char_in inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_point = (req_char_in == CHAR_POINT);
   assign is_sign  = (req_char_in == CHAR_MINUS) || (req_char_in == CHAR_PLUS);
   assign digit    = 4'(req_char_in - CHAR_ZERO);
   assign is_term  = !is_digit && !(is_point && phase_ff != PH_FRAC)
                     && !(is_sign && phase_ff == PH_START);
   assign status.is_term = is_term;

   assign int_sum = (INT_W+4)'(int_ff) * (INT_W+4)'(10) + (INT_W+4)'(digit);

   // one restoring division step: shift in a zero, subtract when it fits
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, dvsr_ff};

   assign mag_wide = 64'({int_ff, quo_ff});
   assign clamp    = mag_wide > 64'h7FFF_FFFF;
   assign mag      = clamp ? {1'b0, {(VALUE_W-1){1'b1}}} : mag_wide[VALUE_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      int_in   = int_ff;
      sat_in   = sat_ff;
      frac_in  = frac_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      quo_in   = quo_ff;
      value_in = value_ff;
      ovf_in   = ovf_ff;

      if (cmd.take_char) begin
         if (is_term) begin
            rem_in  = frac_ff;
            dvsr_in = pow10(count_ff);
            quo_in  = '0;
         end else if (is_digit && phase_ff != PH_FRAC) begin
            phase_in = PH_INT;
            if (int_sum > (INT_W+4)'(INT_MAX)) begin
               int_in = INT_MAX;
               sat_in = 1'b1;
            end else begin
               int_in = int_sum[INT_W-1:0];
            end
         end else if (is_digit) begin
            if (count_ff < COUNT_W'(MAX_FRAC_DIGITS)) begin
               frac_in  = FRAC_ACC_W'(frac_ff * FRAC_ACC_W'(10) + FRAC_ACC_W'(digit));
               count_in = count_ff + 1'b1;
            end
         end else if (is_point) begin
            phase_in = PH_FRAC;
         end else begin
            // sign at the start of a number
            phase_in = PH_INT;
            neg_in   = (req_char_in == CHAR_MINUS);
         end
      end

      if (cmd.div_step) begin
         quo_in = {quo_ff[FRAC_BITS-2:0], rem_ge};
         rem_in = rem_ge ? FRAC_ACC_W'(rem_shift - {1'b0, dvsr_ff})
                         : rem_shift[FRAC_ACC_W-1:0];
      end

      if (cmd.load_out) begin
         value_in = neg_ff ? (VALUE_W'(0) - mag) : mag;
         ovf_in   = sat_ff || clamp;
         phase_in = PH_START;
         neg_in   = 1'b0;
         int_in   = '0;
         sat_in   = 1'b0;
         frac_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         neg_ff   <= 1'b0;
         int_ff   <= '0;
         sat_ff   <= 1'b0;
         frac_ff  <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         sat_ff   <= sat_in;
         frac_ff  <= frac_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      quo_ff   <= quo_in;
      value_ff <= value_in;
      ovf_ff   <= ovf_in;
   end

   assign rsp_value    = value_ff;
   assign rsp_overflow = ovf_ff;

endmodule

>>> hdl/ascii_decimal_to_fixed_point.sv
// ASCII decimal to signed Q15.16 parser. Characters arrive one per transfer on
// the req_ channel; a number is an optional '+' or '-', integer digits, then an
// optional '.' and fraction digits. Any other character ends the number, is
// consumed, and produces one result on the rsp_ channel: the integer part
// (saturated at 32767, which raises rsp_overflow) plus the fraction scaled by
// 2^16 and truncated; fraction digits past the sixth are ignored. A character
// that does not end the number leaves the request side free. A terminating
// character is accepted, then req_stall holds off further transfers while the
// bit-serial restoring divider forms the 16-bit scaled fraction one quotient
// bit per cycle, and until the result register is loaded, which may wait
// further while an earlier result is still held by rsp_stall.
module ascii_decimal_to_fixed_point (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [adfp_pkg::CHAR_W-1:0]         req_char_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [adfp_pkg::VALUE_W-1:0] rsp_value,
   output logic                                rsp_overflow
);
   import adfp_pkg::*;

   adfp_cmd_type    cmd;     // sequencing from the controller
   adfp_status_type status;  // character class back from the datapath

   // controller: accept, run the divider, hand the result over
   adfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: accumulators, divider and result register
   adfp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_char_in  (req_char_in),
      .cmd          (cmd),
      .status       (status),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

endmodule

>>> hdl/adfp_checker.sv
module adfp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [adfp_pkg::VALUE_W-1:0] rsp_value
);
   import adfp_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value))
      else $error("stalled result dropped or changed");

   // drop any result across reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a new result never follows a request transfer directly
   a_rsp_after_div: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && !req_stall))
      else $error("result appeared without divide time");

   // stall requests while the result is being formed
   a_busy_after_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |=> req_stall)
      else $error("request side released too early");

endmodule

bind ascii_decimal_to_fixed_point adfp_checker u_adfp_checker (.*);
